[src/fpd_pkg.sv]
// Shared types, constants and the square-root step for the 3-D distance core.
package fpd_pkg;

    // 16.16 fixed point: whole part sits in the upper half of the word
    localparam int FRAC_BITS        = 16;
    localparam int WORD_W           = 32;
    localparam int AXIS_W           = WORD_W - FRAC_BITS;
    localparam int ROOT_W           = 16;
    localparam int ROOT_START_SHIFT = 'h1E;
    localparam int STEPS_PER_STAGE  = 2;
    localparam int ROOT_STAGES      = ROOT_W / STEPS_PER_STAGE;
    localparam int SIDE_W_DEFAULT   = WORD_W;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [ROOT_W-1:0] t_root;

    typedef struct packed {
        t_word rem;
        t_root root;
    } t_root_state;

    // One restoring step: trial value wraps to 32 bits, compare is signed
    function automatic t_root_state root_step(input t_word rem, input t_root root,
                                              input int shift);
        t_word       base;
        t_word       thr;
        t_root_state res;
        base     = {{(WORD_W-ROOT_W-2){1'b0}}, root, 2'b01};
        thr      = base << shift;
        res.root = {root[ROOT_W-2:0], 1'b0};
        res.rem  = rem;
        if ($signed(rem) >= $signed(thr)) begin
            res.rem     = rem - thr;
            res.root[0] = 1'b1;
        end
        return res;
    endfunction

endpackage

[src/fpd_front.sv]
// Front end: axis differences, squares and the horizontal sum (three stages).
module fpd_front
    import fpd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    input  t_word i_first_x,
    input  t_word i_first_y,
    input  t_word i_first_z,
    input  t_word i_second_x,
    input  t_word i_second_y,
    input  t_word i_second_z,
    output logic  o_valid,
    input  logic  i_stall,
    output t_word o_hsq,
    output t_word o_dysq
);

    logic [2:0] r_valid;
    logic [2:0] w_load;

    t_word w_dx, w_dy, w_dz;
    logic signed [AXIS_W-1:0] r_dx, r_dy, r_dz;
    logic signed [WORD_W-1:0] w_sqx, w_sqy, w_sqz;
    t_word r_sqx, r_sqy, r_sqz;
    t_word r_hsq, r_dysq;

    // a stage loads when empty or when its word moves on
    assign w_load[2] = !r_valid[2] || !i_stall;
    assign w_load[1] = !r_valid[1] || w_load[2];
    assign w_load[0] = !r_valid[0] || w_load[1];
    assign o_stall   = !w_load[0];
    assign o_valid   = r_valid[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (w_load[0]) r_valid[0] <= i_valid;
            if (w_load[1]) r_valid[1] <= r_valid[0];
            if (w_load[2]) r_valid[2] <= r_valid[1];
        end
    end

    // wrapped differences; the shift by FRAC_BITS keeps the upper half
    assign w_dx = i_first_x - i_second_x;
    assign w_dy = i_first_y - i_second_y;
    assign w_dz = i_first_z - i_second_z;

    // signed squares, sign-extended to the word
    assign w_sqx = r_dx * r_dx;
    assign w_sqy = r_dy * r_dy;
    assign w_sqz = r_dz * r_dz;

    always_ff @(posedge i_clk) begin
        if (w_load[0]) begin
            r_dx <= w_dx[WORD_W-1:FRAC_BITS];
            r_dy <= w_dy[WORD_W-1:FRAC_BITS];
            r_dz <= w_dz[WORD_W-1:FRAC_BITS];
        end
        if (w_load[1]) begin
            r_sqx <= w_sqx;
            r_sqy <= w_sqy;
            r_sqz <= w_sqz;
        end
        if (w_load[2]) begin
            r_hsq  <= r_sqx + r_sqz;
            r_dysq <= r_sqy;
        end
    end

    assign o_hsq  = r_hsq;
    assign o_dysq = r_dysq;

endmodule

[src/fpd_root_stage.sv]
// One pipeline stage of the restoring square root: two steps per stage.
module fpd_root_stage
    import fpd_pkg::*;
#(
    parameter int FIRST_SHIFT = ROOT_START_SHIFT,
    parameter int SIDE_W      = SIDE_W_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  t_word             i_rem,
    input  t_root             i_root,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    input  logic              i_stall,
    output t_word             o_rem,
    output t_root             o_root,
    output logic [SIDE_W-1:0] o_side
);

    logic              r_valid;
    logic              w_load;
    t_root_state       w_s1, w_s2;
    t_word             r_rem;
    t_root             r_root;
    logic [SIDE_W-1:0] r_side;

    assign w_load  = !r_valid || !i_stall;
    assign o_stall = !w_load;
    assign o_valid = r_valid;

    // two dependent trial subtractions
    always_comb begin
        w_s1 = root_step(i_rem, i_root, FIRST_SHIFT);
        w_s2 = root_step(w_s1.rem, w_s1.root, FIRST_SHIFT - 2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_rem  <= w_s2.rem;
            r_root <= w_s2.root;
            r_side <= i_side;
        end
    end

    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_side = r_side;

endmodule

[src/fpd_root.sv]
// Pipelined 16-step integer square root with a word carried alongside.
module fpd_root
    import fpd_pkg::*;
#(
    parameter int SIDE_W = SIDE_W_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  t_word             i_rem,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    input  logic              i_stall,
    output t_root             o_root,
    output logic [SIDE_W-1:0] o_side
);

    logic [ROOT_STAGES:0]             w_valid;
    logic [ROOT_STAGES:0]             w_stall;
    t_word [ROOT_STAGES:0]            w_rem;
    t_root [ROOT_STAGES:0]            w_root;
    logic [ROOT_STAGES:0][SIDE_W-1:0] w_side;

    assign w_valid[0]           = i_valid;
    assign o_stall              = w_stall[0];
    assign w_rem[0]             = i_rem;
    assign w_root[0]            = '0;
    assign w_side[0]            = i_side;
    assign w_stall[ROOT_STAGES] = i_stall;

    // stage k handles shifts 30-4k and 28-4k
    for (genvar k = 0; k < ROOT_STAGES; k++) begin : g_stage
        fpd_root_stage #(
            .FIRST_SHIFT (ROOT_START_SHIFT - 2 * STEPS_PER_STAGE * k),
            .SIDE_W      (SIDE_W)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .o_stall (w_stall[k]),
            .i_rem   (w_rem[k]),
            .i_root  (w_root[k]),
            .i_side  (w_side[k]),
            .o_valid (w_valid[k+1]),
            .i_stall (w_stall[k+1]),
            .o_rem   (w_rem[k+1]),
            .o_root  (w_root[k+1]),
            .o_side  (w_side[k+1])
        );
    end

    assign o_valid = w_valid[ROOT_STAGES];
    assign o_root  = w_root[ROOT_STAGES];
    assign o_side  = w_side[ROOT_STAGES];

endmodule

[src/fpd_combine.sv]
// Squares the horizontal distance and adds dy squared (two stages).
module fpd_combine
    import fpd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    input  t_root i_h,
    input  t_word i_dysq,
    output logic  o_valid,
    input  logic  i_stall,
    output t_word o_dsq
);

    logic [1:0] r_valid;
    logic [1:0] w_load;
    t_word      w_hh;
    t_word      r_hh, r_dysq, r_dsq;

    assign w_load[1] = !r_valid[1] || !i_stall;
    assign w_load[0] = !r_valid[0] || w_load[1];
    assign o_stall   = !w_load[0];
    assign o_valid   = r_valid[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (w_load[0]) r_valid[0] <= i_valid;
            if (w_load[1]) r_valid[1] <= r_valid[0];
        end
    end

    // 16x16 product fits the word
    assign w_hh = i_h * i_h;

    always_ff @(posedge i_clk) begin
        if (w_load[0]) begin
            r_hh   <= w_hh;
            r_dysq <= i_dysq;
        end
        if (w_load[1]) begin
            r_dsq <= r_hh + r_dysq;
        end
    end

    assign o_dsq = r_dsq;

endmodule

[src/fixed_point_distance_3d_core.sv]
// Top level of the 3-D fixed-point distance core.
//
// Input channel: i_valid / o_stall carry one word of two points, six signed
// 16.16 coordinates. Output channel: o_valid / i_stall carry the distance in
// whole units, floor of the square root, 16 bits unsigned.
// A word moves on a rising edge where valid is high and stall is low.
// The pipe has 3 front-end stages (difference, square, sum),
// 8 stages for the first root, 2 stages for h*h + dy*dy and 8 for the
// second root. Each root stage does two restoring steps.
// Throughput is one word per cycle while i_stall stays low; every stage
// has its own valid bit. When the receiver stalls, the last stage holds
// its word and earlier stages keep filling empty slots, so o_stall rises
// only once the pipe is full. Nothing is lost or repeated.
// Reset (synchronous, active low) clears all valid bits; no other state.
module fixed_point_distance_3d_core
    import fpd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    input  t_word i_first_x,
    input  t_word i_first_y,
    input  t_word i_first_z,
    input  t_word i_second_x,
    input  t_word i_second_y,
    input  t_word i_second_z,
    output logic  o_valid,
    input  logic  i_stall,
    output t_root o_distance
);

    logic  w_f_valid, w_f_stall;
    t_word w_hsq, w_dysq;
    logic  w_h_valid, w_h_stall;
    t_root w_h;
    t_word w_h_dysq;
    logic  w_c_valid, w_c_stall;
    t_word w_dsq;

    // difference, squares and horizontal sum
    fpd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_first_x  (i_first_x),
        .i_first_y  (i_first_y),
        .i_first_z  (i_first_z),
        .i_second_x (i_second_x),
        .i_second_y (i_second_y),
        .i_second_z (i_second_z),
        .o_valid    (w_f_valid),
        .i_stall    (w_f_stall),
        .o_hsq      (w_hsq),
        .o_dysq     (w_dysq)
    );

    // horizontal distance; dy squared rides along
    fpd_root #(
        .SIDE_W (WORD_W)
    ) u_root_h (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_stall (w_f_stall),
        .i_rem   (w_hsq),
        .i_side  (w_dysq),
        .o_valid (w_h_valid),
        .i_stall (w_h_stall),
        .o_root  (w_h),
        .o_side  (w_h_dysq)
    );

    fpd_combine u_combine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_h_valid),
        .o_stall (w_h_stall),
        .i_h     (w_h),
        .i_dysq  (w_h_dysq),
        .o_valid (w_c_valid),
        .i_stall (w_c_stall),
        .o_dsq   (w_dsq)
    );

    // final root; its last stage is the output register
    fpd_root #(
        .SIDE_W (1)
    ) u_root_d (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_c_valid),
        .o_stall (w_c_stall),
        .i_rem   (w_dsq),
        .i_side  (1'b0),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_root  (o_distance),
        .o_side  ()
    );

endmodule

[sim/tb.sv]
// Self-checking testbench for the pipelined 3-D fixed-point distance core.
`timescale 1ns / 1ps

module tb;
    import fpd_pkg::*;

    localparam int          CLK_HALF    = 10;
    localparam int          RESET_LEN   = 4;
    localparam int          RANDOM_WORDS = 500;
    localparam int          DRAIN_WAIT  = 30;
    localparam int unsigned CYCLE_LIMIT = 200000;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_COIN,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_mode;

    // Expected distances in arrival order, computed from each accepted point pair
    class distance_scoreboard;
        t_root       pending_q[$];
        int unsigned n_words;
        int unsigned n_checked;
        int unsigned n_errors;

        // Restoring root, 16 steps; trial wraps to 32 bits, signed compare
        function t_word int_root(input t_word rem_in);
            t_word rem;
            t_word root;
            t_word thr;
            rem  = rem_in;
            root = '0;
            for (int sh = ROOT_START_SHIFT; sh >= 0; sh -= 2) begin
                thr  = {root[WORD_W-3:0], 2'b01} << sh;
                root = root << 1;
                if ($signed(rem) >= $signed(thr)) begin
                    rem     = rem - thr;
                    root[0] = 1'b1;
                end
            end
            return root;
        endfunction

        // Whole-unit axis delta: wrapped difference, arithmetic shift
        function t_word axis_delta(input t_word a, input t_word b);
            t_word diff;
            diff = a - b;
            return $signed(diff) >>> FRAC_BITS;
        endfunction

        function t_root calc_distance(input t_word ax, input t_word ay, input t_word az,
                                      input t_word bx, input t_word by, input t_word bz);
            t_word dx, dy, dz, h;
            dx = axis_delta(ax, bx);
            dy = axis_delta(ay, by);
            dz = axis_delta(az, bz);
            h  = int_root(dx * dx + dz * dz);
            return t_root'(int_root(h * h + dy * dy));
        endfunction

        function void note_word(input t_word ax, input t_word ay, input t_word az,
                                input t_word bx, input t_word by, input t_word bz);
            pending_q.push_back(calc_distance(ax, ay, az, bx, by, bz));
            n_words++;
        endfunction

        function void check_distance(input t_root got);
            t_root want;
            if (pending_q.size() == 0) begin
                $error("distance: expected none, actual %0d", got);
                n_errors++;
            end else begin
                want = pending_q.pop_front();
                n_checked++;
                if (got !== want) begin
                    $error("distance: expected %0d, actual %0d", want, got);
                    n_errors++;
                end
            end
        endfunction
    endclass

    logic  i_clk      = 1'b0;
    logic  i_rst_n    = 1'b0;
    logic  i_valid    = 1'b0;
    logic  i_stall    = 1'b0;
    t_word i_first_x  = '0;
    t_word i_first_y  = '0;
    t_word i_first_z  = '0;
    t_word i_second_x = '0;
    t_word i_second_y = '0;
    t_word i_second_z = '0;
    logic  o_stall;
    logic  o_valid;
    t_root o_distance;

    distance_scoreboard sb;
    int unsigned        cycle_count = 0;
    int                 burst_left  = 0;
    t_stall_mode        stall_mode  = STALL_NONE;
    int unsigned        stall_cycle = 0;

    fixed_point_distance_3d_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_first_x  (i_first_x),
        .i_first_y  (i_first_y),
        .i_first_z  (i_first_z),
        .i_second_x (i_second_x),
        .i_second_y (i_second_y),
        .i_second_z (i_second_z),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_distance (o_distance)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    // Receiver stall: modes switch after random stretches
    always @(posedge i_clk) begin
        if (stall_cycle == 0) begin
            stall_mode  <= t_stall_mode'($urandom_range(0, 3));
            stall_cycle <= $urandom_range(20, 120);
        end else begin
            stall_cycle <= stall_cycle - 1;
        end
        case (stall_mode)
            STALL_NONE:  i_stall <= 1'b0;
            STALL_COIN:  i_stall <= 1'($urandom_range(0, 1));
            STALL_HEAVY: i_stall <= ($urandom_range(0, 7) != 0);
            default:     i_stall <= stall_cycle[2];
        endcase
    end

    // Monitor both channels on the edge where a word moves
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                sb.note_word(i_first_x, i_first_y, i_first_z,
                             i_second_x, i_second_y, i_second_z);
            if (o_valid && !i_stall)
                sb.check_distance(o_distance);
        end
    end

    // Present one word and hold it until accepted; gaps fall between bursts
    task automatic send_pair(input t_word ax, input t_word ay, input t_word az,
                             input t_word bx, input t_word by, input t_word bz);
        int gap;
        i_valid    <= 1'b1;
        i_first_x  <= ax;
        i_first_y  <= ay;
        i_first_z  <= az;
        i_second_x <= bx;
        i_second_y <= by;
        i_second_z <= bz;
        do @(posedge i_clk); while (o_stall);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    function automatic t_word pick_corner();
        case ($urandom_range(0, 5))
            0:       return 32'h0000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'hFFFF_FFFF;
            4:       return 32'h0001_0000;
            default: return $urandom;
        endcase
    endfunction

    // Second coordinate near the first, offset within a random power-of-two span
    function automatic t_word near(input t_word base);
        t_word span;
        span = 32'h1 << $urandom_range(8, 30);
        return base + (($urandom & ((span << 1) - 1)) - span);
    endfunction

    task automatic send_random_pair();
        t_word a[3];
        t_word b[3];
        int    axis;
        int    kind;
        kind = $urandom_range(0, 9);
        axis = $urandom_range(0, 2);
        for (int k = 0; k < 3; k++) begin
            a[k] = $urandom;
            if (kind <= 3)
                b[k] = $urandom;
            else if (kind <= 6)
                b[k] = near(a[k]);
            else if (kind <= 8) begin
                a[k] = pick_corner();
                b[k] = pick_corner();
            end else
                b[k] = (k == axis) ? $urandom : a[k];
        end
        send_pair(a[0], a[1], a[2], b[0], b[1], b[2]);
    endtask

    initial begin
        sb = new();
        repeat (RESET_LEN) @(posedge i_clk);
        i_rst_n <= 1'b1;
        burst_left = $urandom_range(1, 24);

        // Directed: zero, single axes, extremes, wraps in sums and differences
        send_pair(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0);
        send_pair(32'h0003_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        send_pair(32'h0, 32'h0004_0000, 32'h0, 32'h0, 32'h0, 32'h0);
        send_pair(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0005_0000);
        send_pair(32'h0003_8000, 32'h0004_0000, 32'h000C_0000,
                  32'h0, 32'h0, 32'h0);
        // difference overflow in both directions
        send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        // horizontal sum at 2^31 (reads negative) and just below it
        send_pair(32'h0, 32'h0, 32'h0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_pair(32'h0, 32'h0, 32'h0, 32'h8000_0000, 32'h0, 32'h8000_0000);
        send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0);
        // second sum reaches or passes 2^31
        send_pair(32'h7FFF_0000, 32'h0, 32'h7FFF_0000, 32'h0, 32'h8000_0000, 32'h0);
        send_pair(32'h0, 32'h0, 32'h0, 32'h8000_0000, 32'h8000_0000, 32'h0);
        // fraction bits only, then alternating bit patterns and identical points
        send_pair(32'h0000_FFFF, 32'h0000_FFFF, 32'h0000_FFFF, 32'h0, 32'h0, 32'h0);
        send_pair(32'h0, 32'h0, 32'h0, 32'h0000_0001, 32'h0000_FFFF, 32'h0000_8000);
        send_pair(32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'hAAAA_AAAA,
                  32'h5555_5555, 32'h5555_5555, 32'h5555_5555);
        send_pair(32'h5555_5555, 32'h5555_5555, 32'h5555_5555,
                  32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'hAAAA_AAAA);
        send_pair(32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_F0F0,
                  32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_F0F0);

        repeat (RANDOM_WORDS) send_random_pair();

        // Drain, then watch for stray results
        i_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("tb: %0d point pairs sent, %0d distances checked, %0d mismatches",
                 sb.n_words, sb.n_checked, sb.n_errors);
        $display("tb: covered axis extremes, difference and sum wraps, bursts and stalls");
        if (sb.n_errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
